// ===== hw/rtl/hfps_pkg.sv =====
// Shared types, constants and binary16 helpers for the HDR frame peak statistics block.
// No dependencies; used by hfps_pixel, hfps_accum and the top level.
package hfps_pkg;

	localparam int unsigned ColW = 14;
	localparam int unsigned RowW = 14;
	localparam int unsigned FixW = 40;

	localparam logic [4:0]  ExpAllOnes = 5'd31;
	localparam logic [15:0] HalfOne    = 16'h3C00;
	localparam logic [14:0] MaxWidth   = 15'd16384;
	localparam logic [14:0] MaxHeight  = 15'd16384;
	localparam logic [28:0] BrightMax  = 29'h1FFF_FFFF;
	localparam logic [28:0] PixMax     = 29'h1FFF_FFFF;
	localparam logic [29:0] BadMax     = 30'h3FFF_FFFF;

	// register index, taken from paddr[2]
	localparam logic RegFrameWidth = 1'b0;

	typedef struct packed {
		logic [15:0]     peak;
		logic [1:0]      chan;
		logic [1:0]      nonfinite;
		logic            bright;
		logic            inf;
		logic [FixW-1:0] peak_fix;
		logic            eof;
	} hfps_pix_t;

	function automatic logic half_exp_ones(input logic [15:0] bits);
		return bits[14:10] == ExpAllOnes;
	endfunction

	// positive and not NaN
	function automatic logic half_usable(input logic [15:0] bits);
		return !bits[15] && !(half_exp_ones(bits) && (bits[9:0] != 10'd0));
	endfunction

	// exact value with 24 fraction bits of a positive finite binary16
	function automatic logic [FixW-1:0] half_to_fixed(input logic [15:0] bits);
		logic [4:0]      e;
		logic [FixW-1:0] m;
		e = bits[14:10];
		m = {{(FixW-11){1'b0}}, 1'b1, bits[9:0]};
		if (e == 5'd0) begin
			return {{(FixW-10){1'b0}}, bits[9:0]};
		end
		return m << (e - 5'd1);
	endfunction

endpackage

// ===== hw/rtl/hfps_pixel.sv =====
// Per-pixel stage: peak selection, flags and fixed-point peak, registered as stage 2.
// Depends on hfps_pkg.
module hfps_pixel import hfps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  logic [15:0] red_s1,
	input  logic [15:0] green_s1,
	input  logic [15:0] blue_s1,
	input  logic        eof_s1,
	output logic        ready_s1,
	output logic        valid_s2,
	output hfps_pix_t   pix_s2,
	input  logic        take_s2
);

	logic [15:0] chans [3];
	hfps_pix_t   pix_d;
	logic [1:0]  nf_cnt;
	logic        load;

	assign chans[0] = red_s1;
	assign chans[1] = green_s1;
	assign chans[2] = blue_s1;

	always_comb begin
		logic [15:0] peak;
		logic [1:0]  chan;
		peak   = 16'd0;
		chan   = 2'd0;
		nf_cnt = 2'd0;
		for (int c = 0; c < 3; c++) begin
			nf_cnt = nf_cnt + {1'b0, half_exp_ones(chans[c])};
			// strict compare keeps the first channel on ties
			if (half_usable(chans[c]) && (chans[c] > peak)) begin
				peak = chans[c];
				chan = 2'(c);
			end
		end
		pix_d.peak      = peak;
		pix_d.chan      = chan;
		pix_d.nonfinite = nf_cnt;
		pix_d.bright    = peak > HalfOne;
		pix_d.inf       = half_exp_ones(peak);
		pix_d.peak_fix  = half_to_fixed(peak);
		pix_d.eof       = eof_s1;
	end

	assign load     = !valid_s2 || take_s2;
	assign ready_s1 = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid_s1) begin
			pix_s2 <= pix_d;
		end
	end

endmodule

// ===== hw/rtl/hfps_accum.sv =====
// Frame statistics state, raster position counters and the result register.
// Depends on hfps_pkg.
module hfps_accum import hfps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [14:0]      frame_width_q,
	input  logic             valid_s2,
	input  hfps_pix_t        pix_s2,
	output logic             take_s2,
	output logic             stats_valid,
	input  logic             stats_stall,
	output logic [15:0]      max_component_bits,
	output logic [ColW-1:0]  max_at_x,
	output logic [RowW-1:0]  max_at_y,
	output logic [1:0]       max_channel,
	output logic [28:0]      bright_pixels,
	output logic [29:0]      nonfinite_components,
	output logic [63:0]      peak_sum,
	output logic [28:0]      pixel_total
);

	logic [15:0]     best_q;
	logic [ColW-1:0] best_x_q;
	logic [RowW-1:0] best_y_q;
	logic [1:0]      best_chan_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [28:0]     bright_q;
	logic [29:0]     bad_q;
	logic [63:0]     sum_q;
	logic [28:0]     pix_q;

	logic [15:0]     best_n;
	logic [ColW-1:0] best_x_n;
	logic [RowW-1:0] best_y_n;
	logic [1:0]      best_chan_n;
	logic [ColW-1:0] col_n;
	logic [RowW-1:0] row_n;
	logic [28:0]     bright_n;
	logic [29:0]     bad_n;
	logic [63:0]     sum_n;
	logic [28:0]     pix_n;

	logic [14:0] width_eff;
	logic [14:0] col_inc;
	logic [14:0] row_inc;
	logic [30:0] bad_sum;
	logic [64:0] sum_wide;
	logic        out_free;

	assign out_free = !stats_valid || !stats_stall;
	assign take_s2  = valid_s2 && (!pix_s2.eof || out_free);

	always_comb begin
		if (frame_width_q == 15'd0) begin
			width_eff = 15'd1;
		end else if (frame_width_q > MaxWidth) begin
			width_eff = MaxWidth;
		end else begin
			width_eff = frame_width_q;
		end

		if (pix_s2.peak > best_q) begin
			best_n      = pix_s2.peak;
			best_x_n    = col_q;
			best_y_n    = row_q;
			best_chan_n = pix_s2.chan;
		end else begin
			best_n      = best_q;
			best_x_n    = best_x_q;
			best_y_n    = best_y_q;
			best_chan_n = best_chan_q;
		end

		bad_sum = {1'b0, bad_q} + {29'd0, pix_s2.nonfinite};
		bad_n   = (bad_sum > {1'b0, BadMax}) ? BadMax : bad_sum[29:0];

		bright_n = (pix_s2.bright && (bright_q != BrightMax)) ? bright_q + 29'd1 : bright_q;
		pix_n    = (pix_q != PixMax) ? pix_q + 29'd1 : pix_q;

		sum_wide = {1'b0, sum_q} + {{(65-FixW){1'b0}}, pix_s2.peak_fix};
		sum_n    = (pix_s2.inf || sum_wide[64]) ? '1 : sum_wide[63:0];

		col_inc = {1'b0, col_q} + 15'd1;
		row_inc = {1'b0, row_q} + 15'd1;
		if (col_inc >= width_eff) begin
			col_n = '0;
			row_n = (row_inc >= MaxHeight) ? '0 : row_inc[RowW-1:0];
		end else begin
			col_n = col_inc[ColW-1:0];
			row_n = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_chan_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
			bright_q    <= '0;
			bad_q       <= '0;
			sum_q       <= '0;
			pix_q       <= '0;
			stats_valid <= 1'b0;
		end else begin
			if (take_s2 && pix_s2.eof) begin
				// end of frame: emit and clear
				best_q      <= '0;
				best_x_q    <= '0;
				best_y_q    <= '0;
				best_chan_q <= '0;
				col_q       <= '0;
				row_q       <= '0;
				bright_q    <= '0;
				bad_q       <= '0;
				sum_q       <= '0;
				pix_q       <= '0;
				stats_valid <= 1'b1;
			end else begin
				if (take_s2) begin
					best_q      <= best_n;
					best_x_q    <= best_x_n;
					best_y_q    <= best_y_n;
					best_chan_q <= best_chan_n;
					col_q       <= col_n;
					row_q       <= row_n;
					bright_q    <= bright_n;
					bad_q       <= bad_n;
					sum_q       <= sum_n;
					pix_q       <= pix_n;
				end
				if (!stats_stall) begin
					stats_valid <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && pix_s2.eof) begin
			max_component_bits   <= best_n;
			max_at_x             <= best_x_n;
			max_at_y             <= best_y_n;
			max_channel          <= best_chan_n;
			bright_pixels        <= bright_n;
			nonfinite_components <= bad_n;
			peak_sum             <= sum_n;
			pixel_total          <= pix_n;
		end
	end

endmodule

// ===== hw/rtl/hdr_frame_peak_statistics_top.sv =====
// HDR frame peak statistics: one pixel request per clock, frame statistics at end of frame.
// A result is registered once its end-of-frame pixel request has passed the input and stage-2 registers.
// Throughput: one pixel per cycle; the input stalls only when an end-of-frame request
// reaches the accumulator while the previous result is still held and stalled.
// Reset (arst_n, async): statistics cleared, frame_width = 1, pipeline and result empty.
// Depends on hfps_pkg, hfps_pixel and hfps_accum.
module hdr_frame_peak_statistics_top import hfps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,

	// configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,

	// pixel requests
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  logic [15:0]      red_bits,
	input  logic [15:0]      green_bits,
	input  logic [15:0]      blue_bits,
	input  logic             end_of_frame,

	// frame statistics requests
	output logic             stats_valid,
	input  logic             stats_stall,
	output logic [15:0]      max_component_bits,
	output logic [ColW-1:0]  max_at_x,
	output logic [RowW-1:0]  max_at_y,
	output logic [1:0]       max_channel,
	output logic [28:0]      bright_pixels,
	output logic [29:0]      nonfinite_components,
	output logic [63:0]      peak_sum,
	output logic [28:0]      pixel_total
);

	logic [14:0] frame_width_q;

	// stage 1: input register
	logic        valid_s1;
	logic [15:0] red_s1;
	logic [15:0] green_s1;
	logic [15:0] blue_s1;
	logic        eof_s1;
	logic        ready_s1;
	logic        accept;

	// stage 2: per-pixel summary
	logic        valid_s2;
	hfps_pix_t   pix_s2;
	logic        take_s2;

	// register write: hold the width until software changes it
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 15'd1;
		end else if (psel && penable && pwrite && (paddr[2] == RegFrameWidth)) begin
			frame_width_q <= pwdata[14:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == RegFrameWidth) begin
			prdata = {17'd0, frame_width_q};
		end
	end

	// input register: accept while empty or while its content moves on
	assign pixel_stall = valid_s1 && !ready_s1;
	assign accept      = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ready_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red_bits;
			green_s1 <= green_bits;
			blue_s1  <= blue_bits;
			eof_s1   <= end_of_frame;
		end
	end

	// peak select and fixed-point conversion, no dependence on frame state
	hfps_pixel u_pixel (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.red_s1   (red_s1),
		.green_s1 (green_s1),
		.blue_s1  (blue_s1),
		.eof_s1   (eof_s1),
		.ready_s1 (ready_s1),
		.valid_s2 (valid_s2),
		.pix_s2   (pix_s2),
		.take_s2  (take_s2)
	);

	// running statistics: best component, counters, saturating 64-bit sum
	hfps_accum u_accum (
		.clk                  (clk),
		.arst_n               (arst_n),
		.frame_width_q        (frame_width_q),
		.valid_s2             (valid_s2),
		.pix_s2               (pix_s2),
		.take_s2              (take_s2),
		.stats_valid          (stats_valid),
		.stats_stall          (stats_stall),
		.max_component_bits   (max_component_bits),
		.max_at_x             (max_at_x),
		.max_at_y             (max_at_y),
		.max_channel          (max_channel),
		.bright_pixels        (bright_pixels),
		.nonfinite_components (nonfinite_components),
		.peak_sum             (peak_sum),
		.pixel_total          (pixel_total)
	);

endmodule

// ===== tb/hdr_frame_peak_statistics_top_test.sv =====
// Testbench for hdr_frame_peak_statistics_top: drives binary16 pixel requests, predicts the
// frame statistics and checks each result request field by field; widths set over APB.
// Depends on hfps_pkg and the hdr_frame_peak_statistics_top RTL.
module hdr_frame_peak_statistics_top_test import hfps_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// binary16 patterns used by the directed requests
	localparam logic [15:0] HalfZero     = 16'h0000;
	localparam logic [15:0] HalfNegZero  = 16'h8000;
	localparam logic [15:0] HalfPosInf   = 16'h7C00;
	localparam logic [15:0] HalfNegInf   = 16'hFC00;
	localparam logic [15:0] HalfMaxFin   = 16'h7BFF;
	localparam logic [15:0] HalfQuietNan = 16'h7E00;
	localparam logic [15:0] HalfMinSub   = 16'h0001;
	localparam logic [15:0] HalfMaxSub   = 16'h03FF;
	localparam logic [15:0] HalfMinNorm  = 16'h0400;
	localparam logic [15:0] HalfTwo      = 16'h4000;
	localparam logic [15:0] HalfSignBit  = 16'h8000;

	// results come after the end-of-frame request passes the pipeline registers; allow a margin
	localparam int PipeDrain  = 6;
	localparam int QuietLimit = 5000;
	localparam int LongHold   = 400;

	// random phases: width written, pixels sent, one end of frame in so many pixels
	localparam int NumPhases = 11;
	localparam int HoldPhase = 6;
	localparam int PhaseWidth [NumPhases] = '{3, 0, 40, 3, 32767, 16385, 1, 16384, 7, 2, 13};
	localparam int PhaseItems [NumPhases] = '{150, 100, 150, 100, 300, 60, 150, 40, 150, 100, 250};
	localparam int PhaseEofOdds [NumPhases] = '{8, 4, 30, 6, 300, 20, 2, 10, 8, 5, 10};

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        eof;
	} pixel_t;

	typedef struct packed {
		logic [15:0] peak_bits;
		logic [13:0] x;
		logic [13:0] y;
		logic [1:0]  chan;
		logic [28:0] bright;
		logic [29:0] bad;
		logic [63:0] sum;
		logic [28:0] pixels;
	} frame_stats_t;

	typedef struct packed {
		frame_stats_t st;
		logic [13:0]  col;
		logic [13:0]  row;
	} frame_acc_t;

	logic        clk;
	logic        arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	logic [15:0] red_bits = '0;
	logic [15:0] green_bits = '0;
	logic [15:0] blue_bits = '0;
	logic        end_of_frame = 1'b0;

	logic        stats_valid;
	logic        stats_stall = 1'b0;
	logic [15:0] max_component_bits;
	logic [13:0] max_at_x;
	logic [13:0] max_at_y;
	logic [1:0]  max_channel;
	logic [28:0] bright_pixels;
	logic [29:0] nonfinite_components;
	logic [63:0] peak_sum;
	logic [28:0] pixel_total;

	// stimulus and prediction state
	pixel_t       pending_pixels [$];
	frame_stats_t expected_stats [$];
	frame_acc_t   frame_acc = '0;
	logic [14:0]  frame_width_setting = 15'd1;
	pixel_t       on_wire = '0;
	int           pixels_queued = 0;
	int           pixels_taken = 0;
	int           mismatches = 0;

	// idle control for both sides
	bit calm = 1'b0;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;
	int send_gap = 0;
	int send_quiet = 0;
	int stall_gap = 0;
	int stall_quiet = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	hdr_frame_peak_statistics_top dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.pixel_valid         (pixel_valid),
		.pixel_stall         (pixel_stall),
		.red_bits            (red_bits),
		.green_bits          (green_bits),
		.blue_bits           (blue_bits),
		.end_of_frame        (end_of_frame),
		.stats_valid         (stats_valid),
		.stats_stall         (stats_stall),
		.max_component_bits  (max_component_bits),
		.max_at_x            (max_at_x),
		.max_at_y            (max_at_y),
		.max_channel         (max_channel),
		.bright_pixels       (bright_pixels),
		.nonfinite_components(nonfinite_components),
		.peak_sum            (peak_sum),
		.pixel_total         (pixel_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fold one accepted pixel request into the running frame statistics and, on the
	// end-of-frame pixel, queue the statistics the block has to report.
	task automatic fold_pixel(input pixel_t px);
		logic [15:0] comp [3];
		logic [15:0] peak;
		logic [4:0]  expo;
		logic        is_nan;
		logic [63:0] add;
		int          width;
		comp[0] = px.red;
		comp[1] = px.green;
		comp[2] = px.blue;
		// clamp the width the way the block reads it
		width = int'(frame_width_setting);
		if (width == 0)
			width = 1;
		if (width > int'(MaxWidth))
			width = int'(MaxWidth);
		peak = '0;
		for (int c = 0; c < 3; c++) begin
			expo = comp[c][14:10];
			is_nan = (expo == ExpAllOnes) && (comp[c][9:0] != 10'd0);
			if (expo == ExpAllOnes && frame_acc.st.bad != BadMax)
				frame_acc.st.bad++;
			// negatives and NaN never count; strict compare keeps the first of equals
			if (!comp[c][15] && !is_nan) begin
				if (comp[c] > peak)
					peak = comp[c];
				if (comp[c] > frame_acc.st.peak_bits) begin
					frame_acc.st.peak_bits = comp[c];
					frame_acc.st.x = frame_acc.col;
					frame_acc.st.y = frame_acc.row;
					frame_acc.st.chan = 2'(c);
				end
			end
		end
		if (peak > HalfOne && frame_acc.st.bright != BrightMax)
			frame_acc.st.bright++;
		// an infinite peak pins the sum; otherwise add the exact value and saturate
		if (peak[14:10] == ExpAllOnes) begin
			frame_acc.st.sum = '1;
		end else begin
			if (peak[14:10] == 5'd0)
				add = 64'(peak[9:0]);
			else
				add = 64'({1'b1, peak[9:0]}) << (peak[14:10] - 5'd1);
			if (frame_acc.st.sum > ~add)
				frame_acc.st.sum = '1;
			else
				frame_acc.st.sum += add;
		end
		if (frame_acc.st.pixels != PixMax)
			frame_acc.st.pixels++;
		// a column at or past the width ends the line, even after a width change
		if (int'(frame_acc.col) + 1 >= width) begin
			frame_acc.col = '0;
			if (int'(frame_acc.row) + 1 >= int'(MaxHeight))
				frame_acc.row = '0;
			else
				frame_acc.row++;
		end else begin
			frame_acc.col++;
		end
		if (px.eof) begin
			expected_stats.push_back(frame_acc.st);
			frame_acc = '0;
		end
	endtask

	// Draw one binary16 component: mostly ordinary values, with ties, signed zeros,
	// subnormals, negatives and an occasional infinity or NaN.
	function automatic logic [15:0] draw_half();
		case ($urandom_range(0, 63))
			0: return HalfPosInf;
			1: return HalfNegInf;
			2: return {1'($urandom_range(0, 1)), ExpAllOnes, 10'($urandom_range(1, 1023))};
			3, 4, 5: return {1'($urandom_range(0, 1)), 5'd0, 10'($urandom())};
			6: return HalfOne;
			7: return HalfMaxFin;
			8: return HalfTwo;
			9: return HalfZero;
			10: return HalfNegZero;
			11, 12, 13, 14, 15, 16, 17, 18:
				return {1'b1, 5'($urandom_range(0, 30)), 10'($urandom())};
			19, 20, 21, 22: return 16'($urandom());
			default: return {1'b0, 5'($urandom_range(0, 30)), 10'($urandom())};
		endcase
	endfunction

	// Pick the next idle burst for one side; hold quiet stretches with no idling at all.
	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		case ($urandom_range(0, 15))
			0: quiet = $urandom_range(40, 150);
			1, 2: return $urandom_range(1, 19);
			default: ;
		endcase
		return 0;
	endfunction

	task automatic queue_pixel(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b, input logic eof);
		pending_pixels.push_back('{red: r, green: g, blue: b, eof: eof});
		pixels_queued++;
	endtask

	// Wait until every queued request is taken and every result has come back, then
	// let the pipeline settle, since pixels without a result may still be in flight.
	task automatic drain();
		while (pixels_taken != pixels_queued || expected_stats.size() != 0)
			@(posedge clk);
		repeat (PipeDrain) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, name,
					want, got);
		end
	endfunction

	// Pixel driver: advance to the next pending request once the current one is taken,
	// hold the payload while stalled, insert random idle bursts between requests.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				fold_pixel(on_wire);
				pixels_taken++;
			end
			if (!pixel_valid || !pixel_stall) begin
				if (send_gap > 0) begin
					pixel_valid <= 1'b0;
					send_gap--;
				end else if (pending_pixels.size() != 0) begin
					on_wire = pending_pixels.pop_front();
					red_bits <= on_wire.red;
					green_bits <= on_wire.green;
					blue_bits <= on_wire.blue;
					end_of_frame <= on_wire.eof;
					pixel_valid <= 1'b1;
					if (!calm)
						send_gap = draw_gap(send_quiet);
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off so that results
	// back up and the block has to stall its pixel input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold_req && !long_hold_done) begin
				hold_left = LongHold;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				stats_stall <= 1'b1;
				hold_left--;
			end else if (stall_gap > 0) begin
				stats_stall <= 1'b1;
				stall_gap--;
			end else begin
				stats_stall <= 1'b0;
				if (!calm)
					stall_gap = draw_gap(stall_quiet);
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		frame_stats_t want;
		if (arst_n && stats_valid && !stats_stall) begin
			if (expected_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t result request with no frame expected", $realtime);
			end else begin
				want = expected_stats.pop_front();
				check_field("max_component_bits", want.peak_bits, max_component_bits);
				check_field("max_at_x", want.x, max_at_x);
				check_field("max_at_y", want.y, max_at_y);
				check_field("max_channel", want.chan, max_channel);
				check_field("bright_pixels", want.bright, bright_pixels);
				check_field("nonfinite_components", want.bad, nonfinite_components);
				check_field("peak_sum", want.sum, peak_sum);
				check_field("pixel_total", want.pixels, pixel_total);
			end
		end
	end

	// Watchdog: drop the run when nothing moves on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && !pixel_stall) || (stats_valid && !stats_stall)
				|| (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset width of one pixel per line.
		// Nothing positive: all zeros, negative zeros, negative values.
		queue_pixel(HalfZero, HalfZero, HalfZero, 1'b1);
		queue_pixel(HalfNegZero, HalfNegZero, HalfNegZero, 1'b1);
		queue_pixel(HalfSignBit | HalfOne, HalfSignBit | HalfMaxFin, HalfSignBit | HalfMinSub,
			1'b1);
		// Subnormals, equal components (red keeps it), then a pixel just above 1.0.
		queue_pixel(HalfMinSub, HalfMaxSub, HalfMinNorm, 1'b0);
		queue_pixel(HalfOne, HalfOne, HalfOne, 1'b0);
		queue_pixel(HalfOne + 16'd1, HalfOne, HalfZero, 1'b1);
		// Largest finite value; a later equal value must not move the maximum.
		queue_pixel(HalfMaxFin, HalfMaxFin, HalfMaxFin, 1'b0);
		queue_pixel(HalfZero, HalfMaxFin, HalfZero, 1'b1);
		// NaNs of both signs and negative infinity: counted but never the maximum.
		queue_pixel(HalfQuietNan, HalfSignBit | HalfQuietNan, HalfPosInf | 16'd1, 1'b0);
		queue_pixel(HalfNegInf, HalfMinSub, HalfTwo, 1'b1);
		// Infinite peak pins the sum, later pixels keep it saturated.
		queue_pixel(HalfZero, HalfPosInf, HalfMaxFin, 1'b0);
		queue_pixel(HalfOne, HalfZero, HalfZero, 1'b0);
		queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		// Blue wins within a pixel.
		queue_pixel(HalfZero, 16'h3555, HalfTwo, 1'b1);
		drain();

		// Random phases, each at its own width. Frames run on across width changes,
		// so lines can be cut short by a smaller width mid-line.
		for (int p = 0; p < NumPhases; p++) begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {RegFrameWidth, 2'b00};
			pwdata <= 32'(PhaseWidth[p]);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			frame_width_setting = 15'(PhaseWidth[p]);

			if (p == HoldPhase)
				long_hold_req = 1'b1;
			if (p == NumPhases - 1)
				calm = 1'b1;
			for (int i = 0; i < PhaseItems[p]; i++)
				queue_pixel(draw_half(), draw_half(), draw_half(),
					$urandom_range(1, PhaseEofOdds[p]) == 1);
			drain();
		end

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
